FILE: sv/mtrgq_pkg.sv
// Shared types and constants for the multi-type resource grant queue.
package mtrgq_pkg;

	localparam int QUEUE_DEPTH_DEF = 16;
	localparam int NUM_TYPES_DEF   = 4;
	localparam int FIELD_TYPES     = 4;
	localparam int ID_W            = 8;
	localparam int DEM_W           = 4;
	localparam int UNIT_W          = 8;
	localparam int CNT_OUT_W       = 5;
	localparam int ADDR_W          = 4;
	localparam int DATA_W          = 32;
	localparam int CFG_IDX_W       = 2;
	localparam logic [UNIT_W-1:0] CAP_RESET = 8'd8;

	typedef enum logic [1:0] {
		MODE_SUBMIT  = 2'd0,
		MODE_RELEASE = 2'd1,
		MODE_POLL    = 2'd2
	} mode_t;

	typedef enum logic [2:0] {
		ST_QUEUED   = 3'd0,
		ST_TOO_BIG  = 3'd1,
		ST_FULL     = 3'd2,
		ST_GRANTED  = 3'd3,
		ST_NO_FIT   = 3'd4,
		ST_RELEASED = 3'd5
	} status_t;

	typedef enum logic [1:0] {
		RD_ZERO = 2'd0,
		RD_IDX1 = 2'd1,
		RD_IDX2 = 2'd2
	} rd_sel_t;

	typedef struct packed {
		logic [1:0]       mode;
		logic [ID_W-1:0]  request_id;
		logic [DEM_W-1:0] demand_type0;
		logic [DEM_W-1:0] demand_type1;
		logic [DEM_W-1:0] demand_type2;
		logic [DEM_W-1:0] demand_type3;
	} item_t;

	typedef struct packed {
		logic [2:0]           status;
		logic [ID_W-1:0]      granted_id;
		logic [CNT_OUT_W-1:0] pending_count;
	} result_t;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic    submit;
		logic    release_units;
		logic    scan_start;
		logic    scan_adv;
		logic    take;
		logic    shift;
		logic    dec_len;
		logic    finish;
		status_t fin_status;
		rd_sel_t rd_sel;
	} cmd_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		logic too_big;
		logic full;
		logic len_zero;
		logic fit;
		logic more1;
		logic more2;
	} sts_t;

endpackage

FILE: sv/mtrgq_ctrl.sv
// Controller state machine: sequences submit, release, scan and compaction.
module mtrgq_ctrl (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                start,
	input  logic [1:0]          mode,
	input  mtrgq_pkg::sts_t     sts,
	output mtrgq_pkg::cmd_t     cmd,
	output logic                busy
);

	typedef enum logic [2:0] {
		S_IDLE  = 3'b001,
		S_SCAN  = 3'b010,
		S_SHIFT = 3'b100
	} state_t;

	state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	assign busy = (state_q != S_IDLE);

	always_comb begin
		state_d = state_q;
		cmd = '0;
		cmd.fin_status = mtrgq_pkg::ST_NO_FIT;
		cmd.rd_sel = mtrgq_pkg::RD_ZERO;
		unique case (state_q)
			S_IDLE: begin
				if (start) begin
					unique case (mode)
						mtrgq_pkg::MODE_SUBMIT: begin
							cmd.finish = 1'b1;
							if (sts.too_big) begin
								cmd.fin_status = mtrgq_pkg::ST_TOO_BIG;
							end else if (sts.full) begin
								cmd.fin_status = mtrgq_pkg::ST_FULL;
							end else begin
								cmd.submit = 1'b1;
								cmd.fin_status = mtrgq_pkg::ST_QUEUED;
							end
						end
						mtrgq_pkg::MODE_RELEASE: begin
							cmd.release_units = 1'b1;
							cmd.finish = 1'b1;
							cmd.fin_status = mtrgq_pkg::ST_RELEASED;
						end
						mtrgq_pkg::MODE_POLL: begin
							if (sts.len_zero) begin
								cmd.finish = 1'b1;
								cmd.fin_status = mtrgq_pkg::ST_NO_FIT;
							end else begin
								cmd.scan_start = 1'b1;
								cmd.rd_sel = mtrgq_pkg::RD_ZERO;
								state_d = S_SCAN;
							end
						end
						default: begin
							cmd.finish = 1'b1;
							cmd.fin_status = mtrgq_pkg::ST_NO_FIT;
						end
					endcase
				end
			end
			S_SCAN: begin
				if (sts.fit) begin
					cmd.take = 1'b1;
					if (sts.more1) begin
						cmd.rd_sel = mtrgq_pkg::RD_IDX1;
						state_d = S_SHIFT;
					end else begin
						cmd.dec_len = 1'b1;
						cmd.finish = 1'b1;
						cmd.fin_status = mtrgq_pkg::ST_GRANTED;
						state_d = S_IDLE;
					end
				end else if (sts.more1) begin
					cmd.scan_adv = 1'b1;
					cmd.rd_sel = mtrgq_pkg::RD_IDX1;
				end else begin
					cmd.finish = 1'b1;
					cmd.fin_status = mtrgq_pkg::ST_NO_FIT;
					state_d = S_IDLE;
				end
			end
			S_SHIFT: begin
				// Each cycle moves one later entry down by one place.
				cmd.shift = 1'b1;
				if (sts.more2) begin
					cmd.rd_sel = mtrgq_pkg::RD_IDX2;
				end else begin
					cmd.dec_len = 1'b1;
					cmd.finish = 1'b1;
					cmd.fin_status = mtrgq_pkg::ST_GRANTED;
					state_d = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

endmodule

FILE: sv/mtrgq_dp.sv
// Datapath: capacity and free counters, request memory, scan index and result register.
module mtrgq_dp #(
	parameter int QUEUE_DEPTH = mtrgq_pkg::QUEUE_DEPTH_DEF,
	parameter int NUM_TYPES   = mtrgq_pkg::NUM_TYPES_DEF
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  mtrgq_pkg::item_t                    item,
	input  mtrgq_pkg::cmd_t                     cmd,
	output mtrgq_pkg::sts_t                     sts,
	input  logic                                cfg_we,
	input  logic [mtrgq_pkg::CFG_IDX_W-1:0]     cfg_idx,
	input  logic [mtrgq_pkg::UNIT_W-1:0]        cfg_wdata,
	output logic [mtrgq_pkg::UNIT_W-1:0]        cfg_rdata,
	output logic                                done,
	output mtrgq_pkg::result_t                  result
);

	localparam int IW = $clog2(QUEUE_DEPTH);
	localparam int CW = $clog2(QUEUE_DEPTH + 1);
	localparam int EW = mtrgq_pkg::ID_W + mtrgq_pkg::DEM_W * NUM_TYPES;
	localparam int UW = mtrgq_pkg::UNIT_W;

	logic [NUM_TYPES-1:0][mtrgq_pkg::DEM_W-1:0] dem;
	logic [NUM_TYPES-1:0][mtrgq_pkg::DEM_W-1:0] rd_dem;
	logic [UW-1:0]       cap_q   [NUM_TYPES];
	logic [UW-1:0]       free_q  [NUM_TYPES];
	logic [UW-1:0]       rel_val [NUM_TYPES];
	logic [UW:0]         rel_sum [NUM_TYPES];
	logic [EW-1:0]       mem [QUEUE_DEPTH];
	logic [EW-1:0]       rdata_q;
	logic [EW-1:0]       wr_data;
	logic [IW-1:0]       wr_addr;
	logic [IW-1:0]       rd_addr;
	logic                wr_en;
	logic [IW-1:0]       idx_q;
	logic [CW-1:0]       len_q;
	logic [CW-1:0]       len_d;
	logic [CW:0]         idx_ext;
	logic [mtrgq_pkg::ID_W-1:0] gid_q;
	logic [mtrgq_pkg::ID_W-1:0] rd_id;
	logic [mtrgq_pkg::ID_W-1:0] fin_gid;
	logic                too_big;
	logic                fit;

	// Demand fields; types beyond the input fields always ask for nothing.
	for (genvar t = 0; t < NUM_TYPES; t++) begin : g_dem
		if (t == 0) begin : g_t0
			assign dem[t] = item.demand_type0;
		end else if (t == 1) begin : g_t1
			assign dem[t] = item.demand_type1;
		end else if (t == 2) begin : g_t2
			assign dem[t] = item.demand_type2;
		end else if (t == 3) begin : g_t3
			assign dem[t] = item.demand_type3;
		end else begin : g_tx
			assign dem[t] = '0;
		end
	end

	assign rd_id  = rdata_q[EW-1 -: mtrgq_pkg::ID_W];
	assign rd_dem = rdata_q[mtrgq_pkg::DEM_W*NUM_TYPES-1:0];

	always_comb begin
		too_big = 1'b0;
		fit = 1'b1;
		cfg_rdata = '0;
		for (int t = 0; t < NUM_TYPES; t++) begin
			if (UW'(dem[t]) > cap_q[t]) begin
				too_big = 1'b1;
			end
			if (UW'(rd_dem[t]) > free_q[t]) begin
				fit = 1'b0;
			end
			rel_sum[t] = {1'b0, free_q[t]} + (UW+1)'(dem[t]);
			rel_val[t] = (rel_sum[t] > {1'b0, cap_q[t]}) ? cap_q[t] : rel_sum[t][UW-1:0];
			if (t < mtrgq_pkg::FIELD_TYPES && cfg_idx == mtrgq_pkg::CFG_IDX_W'(t)) begin
				cfg_rdata = cap_q[t];
			end
		end
	end

	// Capacity registers and free counters.
	for (genvar t = 0; t < NUM_TYPES; t++) begin : g_unit
		if (t < mtrgq_pkg::FIELD_TYPES) begin : g_reg
			logic wr_hit;
			assign wr_hit = cfg_we && (cfg_idx == mtrgq_pkg::CFG_IDX_W'(t));
			always_ff @(posedge clk or negedge arst_n) begin
				if (!arst_n) begin
					cap_q[t]  <= mtrgq_pkg::CAP_RESET;
					free_q[t] <= mtrgq_pkg::CAP_RESET;
				end else if (wr_hit) begin
					cap_q[t]  <= cfg_wdata;
					free_q[t] <= cfg_wdata;
				end else if (cmd.release_units) begin
					free_q[t] <= rel_val[t];
				end else if (cmd.take) begin
					free_q[t] <= free_q[t] - UW'(rd_dem[t]);
				end
			end
		end else begin : g_none
			assign cap_q[t]  = '0;
			assign free_q[t] = '0;
		end
	end

	// Request memory: one write port, one registered read port.
	assign wr_en   = cmd.submit || cmd.shift;
	assign wr_addr = cmd.submit ? len_q[IW-1:0] : idx_q;
	assign wr_data = cmd.submit ? {item.request_id, dem} : rdata_q;

	assign idx_ext = (CW+1)'(idx_q);

	always_comb begin
		unique case (cmd.rd_sel)
			mtrgq_pkg::RD_IDX1: rd_addr = IW'(idx_ext + (CW+1)'(1));
			mtrgq_pkg::RD_IDX2: rd_addr = IW'(idx_ext + (CW+1)'(2));
			default:            rd_addr = '0;
		endcase
	end

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		rdata_q <= mem[rd_addr];
	end

	assign sts.too_big  = too_big;
	assign sts.full     = (len_q == CW'(QUEUE_DEPTH));
	assign sts.len_zero = (len_q == '0);
	assign sts.fit      = fit;
	assign sts.more1    = (idx_ext + (CW+1)'(1)) < (CW+1)'(len_q);
	assign sts.more2    = (idx_ext + (CW+1)'(2)) < (CW+1)'(len_q);

	always_comb begin
		len_d = len_q;
		if (cmd.submit) begin
			len_d = len_q + CW'(1);
		end else if (cmd.dec_len) begin
			len_d = len_q - CW'(1);
		end
	end

	assign fin_gid = cmd.take ? rd_id : gid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			len_q  <= '0;
			idx_q  <= '0;
			done   <= 1'b0;
		end else begin
			len_q <= len_d;
			done  <= cmd.finish;
			if (cmd.scan_start) begin
				idx_q <= '0;
			end else if (cmd.scan_adv || cmd.shift) begin
				idx_q <= idx_q + IW'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.take) begin
			gid_q <= rd_id;
		end
		if (cmd.finish) begin
			result.status        <= cmd.fin_status;
			result.granted_id    <= (cmd.fin_status == mtrgq_pkg::ST_GRANTED) ? fin_gid : '0;
			result.pending_count <= mtrgq_pkg::CNT_OUT_W'(len_d);
		end
	end

endmodule

FILE: sv/multi_type_resource_grant_queue_top.sv
// Submit, release and unmatched mode: the result strobe comes in the cycle after the transfer.
// Poll: the result strobe comes in the cycle after the transfer for an empty queue; else the
// request memory's single read port visits one entry per cycle, scanning and then closing the
// gap, and the strobe follows the last entry visited.
// The next item may be started in the cycle the result is shown; results cannot be stalled.
// Reset clears the queue and reloads every capacity and free counter with eight units.
module multi_type_resource_grant_queue_top #(
	parameter int QUEUE_DEPTH = mtrgq_pkg::QUEUE_DEPTH_DEF,
	parameter int NUM_TYPES   = mtrgq_pkg::NUM_TYPES_DEF
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            start,
	output logic                            busy,
	input  mtrgq_pkg::item_t                item,
	output logic                            done,
	output mtrgq_pkg::result_t              result,
	input  logic                            psel,
	input  logic                            penable,
	input  logic                            pwrite,
	input  logic [mtrgq_pkg::ADDR_W-1:0]    paddr,
	input  logic [mtrgq_pkg::DATA_W-1:0]    pwdata,
	output logic [mtrgq_pkg::DATA_W-1:0]    prdata,
	output logic                            pready
);

	mtrgq_pkg::cmd_t cmd;
	mtrgq_pkg::sts_t sts;
	logic                             cfg_we;
	logic [mtrgq_pkg::UNIT_W-1:0]     cfg_rdata;

	assign pready = 1'b1;
	assign cfg_we = psel && penable && pwrite;
	assign prdata = mtrgq_pkg::DATA_W'(cfg_rdata);

	mtrgq_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.mode   (item.mode),
		.sts    (sts),
		.cmd    (cmd),
		.busy   (busy)
	);

	mtrgq_dp #(
		.QUEUE_DEPTH (QUEUE_DEPTH),
		.NUM_TYPES   (NUM_TYPES)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.item      (item),
		.cmd       (cmd),
		.sts       (sts),
		.cfg_we    (cfg_we),
		.cfg_idx   (paddr[3:2]),
		.cfg_wdata (pwdata[mtrgq_pkg::UNIT_W-1:0]),
		.cfg_rdata (cfg_rdata),
		.done      (done),
		.result    (result)
	);

endmodule

FILE: sv/mtrgq_checker.sv
// Port-level checker for the grant queue, bound to the top level.
module mtrgq_checker #(
	parameter int QUEUE_DEPTH = mtrgq_pkg::QUEUE_DEPTH_DEF
) (
	input logic                          clk,
	input logic                          arst_n,
	input logic                          start,
	input logic                          busy,
	input mtrgq_pkg::item_t              item,
	input logic                          done,
	input mtrgq_pkg::result_t            result
);

	// A transfer that is not a poll is answered in the very next cycle.
	a_quick_result: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy && item.mode != mtrgq_pkg::MODE_POLL |=> done)
		else $error("non-poll item did not produce a result on the next cycle");

	// The block is back at rest whenever a result is shown.
	a_idle_on_done: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> !busy)
		else $error("result shown while the block is still busy");

	a_gid_zero: assert property (@(posedge clk) disable iff (!arst_n)
		done && result.status != mtrgq_pkg::ST_GRANTED |-> result.granted_id == '0)
		else $error("granted_id non-zero without a grant");

	a_status_code: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> result.status <= mtrgq_pkg::ST_RELEASED
			&& int'(result.pending_count) <= QUEUE_DEPTH)
		else $error("result status or pending count out of range");

endmodule

bind multi_type_resource_grant_queue_top mtrgq_checker #(
	.QUEUE_DEPTH (QUEUE_DEPTH)
) u_mtrgq_checker (.*);

FILE: dv/tb_multi_type_resource_grant_queue_top.sv
// Self-checking testbench for the multi-type resource grant queue, with a built-in predictor.
module tb_multi_type_resource_grant_queue_top;
	import mtrgq_pkg::*;

	localparam logic [1:0] MODE_UNUSED  = 2'd3;
	localparam int         QDEPTH       = QUEUE_DEPTH_DEF;
	localparam int         REG_STRIDE   = 4;
	localparam int         N_PHASES     = 7;
	localparam int         DRAIN_CYCLES = QUEUE_DEPTH_DEF + 4;
	localparam int         CYCLE_LIMIT  = 400000;

	typedef struct packed {
		logic [ID_W-1:0]                    id;
		logic [FIELD_TYPES-1:0][DEM_W-1:0]  dem;
	} pending_req_t;

	// Mirrors the free counters and the pending queue, and keeps the outcomes still owed.
	class grant_queue_scoreboard;
		logic [UNIT_W-1:0] capacity_units [FIELD_TYPES];
		logic [UNIT_W-1:0] free_units [FIELD_TYPES];
		pending_req_t      waiting_reqs [$];
		result_t           expected_outcomes [$];
		int                failures;

		function new();
			for (int t = 0; t < FIELD_TYPES; t++) begin
				capacity_units[t] = CAP_RESET;
				free_units[t] = CAP_RESET;
			end
			failures = 0;
		endfunction

		function void set_capacity(int t, logic [UNIT_W-1:0] val);
			capacity_units[t] = val;
			free_units[t] = val;
		endfunction

		function bit fits_free(pending_req_t req);
			for (int t = 0; t < FIELD_TYPES; t++)
				if (req.dem[t] > free_units[t])
					return 1'b0;
			return 1'b1;
		endfunction

		function result_t predict_outcome(item_t it);
			result_t      r;
			pending_req_t req;
			logic         too_big;
			int           sum;
			int           hit;
			req.id = it.request_id;
			req.dem[0] = it.demand_type0;
			req.dem[1] = it.demand_type1;
			req.dem[2] = it.demand_type2;
			req.dem[3] = it.demand_type3;
			r.status = ST_NO_FIT;
			r.granted_id = '0;
			case (it.mode)
				MODE_SUBMIT: begin
					too_big = 1'b0;
					for (int t = 0; t < FIELD_TYPES; t++)
						if (req.dem[t] > capacity_units[t])
							too_big = 1'b1;
					if (too_big) begin
						r.status = ST_TOO_BIG;
					end else if (waiting_reqs.size() >= QDEPTH) begin
						r.status = ST_FULL;
					end else begin
						waiting_reqs.push_back(req);
						r.status = ST_QUEUED;
					end
				end
				MODE_RELEASE: begin
					for (int t = 0; t < FIELD_TYPES; t++) begin
						sum = int'(free_units[t]) + int'(req.dem[t]);
						if (sum > int'(capacity_units[t]))
							sum = int'(capacity_units[t]);
						free_units[t] = UNIT_W'(sum);
					end
					r.status = ST_RELEASED;
				end
				MODE_POLL: begin
					// First fit in arrival order; later entries close the gap.
					hit = -1;
					foreach (waiting_reqs[i])
						if (hit < 0 && fits_free(waiting_reqs[i]))
							hit = i;
					if (hit >= 0) begin
						for (int t = 0; t < FIELD_TYPES; t++)
							free_units[t] = free_units[t] - waiting_reqs[hit].dem[t];
						r.granted_id = waiting_reqs[hit].id;
						waiting_reqs.delete(hit);
						r.status = ST_GRANTED;
					end
				end
				default: ;
			endcase
			r.pending_count = CNT_OUT_W'(waiting_reqs.size());
			return r;
		endfunction

		function void note_item(item_t it);
			expected_outcomes.push_back(predict_outcome(it));
		endfunction

		function void check_result(result_t got);
			result_t want;
			if (expected_outcomes.size() == 0) begin
				$error("result with no transfer waiting: status %0d, granted_id %0d",
					got.status, got.granted_id);
				failures++;
				return;
			end
			want = expected_outcomes.pop_front();
			if (got.status !== want.status) begin
				$error("status: expected %0d, actual %0d", want.status, got.status);
				failures++;
			end
			if (got.granted_id !== want.granted_id) begin
				$error("granted_id: expected %0d, actual %0d", want.granted_id, got.granted_id);
				failures++;
			end
			if (got.pending_count !== want.pending_count) begin
				$error("pending_count: expected %0d, actual %0d",
					want.pending_count, got.pending_count);
				failures++;
			end
		endfunction
	endclass

	logic              clk = 1'b0;
	logic              arst_n;
	logic              start;
	logic              busy;
	item_t             item;
	logic              done;
	result_t           result;
	logic              psel;
	logic              penable;
	logic              pwrite;
	logic [ADDR_W-1:0] paddr;
	logic [DATA_W-1:0] pwdata;
	logic [DATA_W-1:0] prdata;
	logic              pready;
	int                cycle_count = 0;

	grant_queue_scoreboard sb;

	multi_type_resource_grant_queue_top dut (.*);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("== FAIL ==");
			$finish;
		end
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if (done)
				sb.check_result(result);
			if (start && !busy)
				sb.note_item(item);
		end
	end

	function automatic item_t make_item(logic [1:0] mode, logic [ID_W-1:0] id,
		int d0, int d1, int d2, int d3);
		item_t it;
		it.mode = mode;
		it.request_id = id;
		it.demand_type0 = DEM_W'(d0);
		it.demand_type1 = DEM_W'(d1);
		it.demand_type2 = DEM_W'(d2);
		it.demand_type3 = DEM_W'(d3);
		return it;
	endfunction

	// Mostly demands that the current capacity admits, now and then anything at all.
	function automatic logic [DEM_W-1:0] fit_demand(logic [UNIT_W-1:0] cap);
		int top;
		top = (cap > 15) ? 15 : int'(cap);
		if ($urandom_range(99, 0) < 85)
			return DEM_W'($urandom_range(top, 0));
		return DEM_W'($urandom_range(15, 0));
	endfunction

	// Leaves start high after the transfer so that a following item can go back to back.
	task automatic issue_item(item_t it, int idle_pct);
		if ($urandom_range(99, 0) < idle_pct) begin
			start <= 1'b0;
			do @(posedge clk); while ($urandom_range(99, 0) < idle_pct);
		end
		start <= 1'b1;
		item <= it;
		do @(posedge clk); while (busy);
	endtask

	task automatic wait_drained();
		while (sb.expected_outcomes.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic write_capacity(int t, logic [UNIT_W-1:0] val);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= ADDR_W'(t * REG_STRIDE);
		pwdata <= DATA_W'(val);
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		sb.set_capacity(t, val);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		@(posedge clk);
	endtask

	task automatic run_directed();
		issue_item(make_item(MODE_POLL, 8'h00, 0, 0, 0, 0), 0);
		issue_item(make_item(MODE_UNUSED, 8'hFF, 15, 15, 15, 15), 0);
		issue_item(make_item(MODE_SUBMIT, 8'hFF, 15, 0, 0, 0), 0);
		issue_item(make_item(MODE_SUBMIT, 8'h00, 0, 0, 0, 9), 0);
		issue_item(make_item(MODE_SUBMIT, 8'h00, 8, 8, 8, 8), 0);
		issue_item(make_item(MODE_POLL, 8'h00, 0, 0, 0, 0), 0);
		issue_item(make_item(MODE_SUBMIT, 8'hA5, 1, 0, 0, 0), 0);
		issue_item(make_item(MODE_POLL, 8'h00, 0, 0, 0, 0), 0);
		issue_item(make_item(MODE_RELEASE, 8'h00, 15, 15, 15, 15), 0);
		issue_item(make_item(MODE_POLL, 8'h00, 0, 0, 0, 0), 0);
		// The first two entries cannot fit, so the next poll takes one from the middle.
		for (int i = 0; i < QDEPTH; i++)
			issue_item(make_item(MODE_SUBMIT, ID_W'(i * 17), (i < 2) ? 8 : i % 8,
				i % 9, (15 - i) % 9, (i * 5) % 9), 0);
		issue_item(make_item(MODE_SUBMIT, 8'h3C, 0, 0, 0, 0), 0);
		issue_item(make_item(MODE_POLL, 8'h00, 0, 0, 0, 0), 0);
	endtask

	task automatic run_random(int count, int idle_pct);
		int    submit_cut;
		int    poll_cut;
		int    pick;
		item_t it;
		submit_cut = 40 + $urandom_range(15, 0);
		poll_cut = submit_cut + 32;
		repeat (count) begin
			pick = $urandom_range(99, 0);
			it.request_id = ID_W'($urandom_range(255, 0));
			it.demand_type0 = DEM_W'($urandom_range(15, 0));
			it.demand_type1 = DEM_W'($urandom_range(15, 0));
			it.demand_type2 = DEM_W'($urandom_range(15, 0));
			it.demand_type3 = DEM_W'($urandom_range(15, 0));
			if (pick < 2) begin
				it.mode = MODE_UNUSED;
			end else if (pick < submit_cut) begin
				it.mode = MODE_SUBMIT;
				it.demand_type0 = fit_demand(sb.capacity_units[0]);
				it.demand_type1 = fit_demand(sb.capacity_units[1]);
				it.demand_type2 = fit_demand(sb.capacity_units[2]);
				it.demand_type3 = fit_demand(sb.capacity_units[3]);
			end else if (pick < poll_cut) begin
				it.mode = MODE_POLL;
			end else begin
				it.mode = MODE_RELEASE;
			end
			issue_item(it, idle_pct);
		end
	endtask

	initial begin
		logic [UNIT_W-1:0] cap;
		int                idle_pct;
		sb = new();
		arst_n <= 1'b0;
		start <= 1'b0;
		item <= '0;
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		paddr <= '0;
		pwdata <= '0;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		run_directed();
		run_random(220, 0);
		start <= 1'b0;

		for (int p = 1; p < N_PHASES; p++) begin
			wait_drained();
			for (int t = 0; t < FIELD_TYPES; t++) begin
				case (p)
					1: cap = 8'd255;
					2: cap = 8'd0;
					3: cap = (t == 0) ? 8'd0 : (t == 1) ? 8'd255 : (t == 2) ? 8'd8 : 8'd15;
					4: cap = UNIT_W'($urandom_range(20, 0));
					5: cap = 8'd15;
					default: cap = (t == 0) ? 8'd3 : (t == 1) ? 8'd8 : (t == 2) ? 8'd1 : 8'd12;
				endcase
				write_capacity(t, cap);
			end
			idle_pct = (p % 3 == 0) ? 0 : (p % 3 == 1) ? 81 : 11;
			run_random((p == 2) ? 100 : 240, idle_pct);
			start <= 1'b0;
		end

		wait_drained();
		if (sb.failures == 0)
			$display("== PASS ==");
		else
			$display("== FAIL ==");
		$finish;
	end

endmodule

FILE: filelist.f
sv/mtrgq_pkg.sv
sv/mtrgq_ctrl.sv
sv/mtrgq_dp.sv
sv/multi_type_resource_grant_queue_top.sv
sv/mtrgq_checker.sv
dv/tb_multi_type_resource_grant_queue_top.sv
